FILE: design/cps_pkg.sv
package cps_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_U      = 16;
    localparam int DW          = COORD_WIDTH + 1;
    localparam int PW          = 2 * DW;
    localparam int NW          = PW + 1;
    localparam int RW          = NW + 1;
    localparam int UW          = FRAC_U + 1;
    localparam int DIV_STAGES  = FRAC_U + 1;
    localparam int MW          = UW + 1 + DW;
    localparam int IN_W        = 6 * COORD_WIDTH;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 2 * COORD_WIDTH;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
        logic signed [DW-1:0]          dx;
        logic signed [DW-1:0]          dy;
        logic                          neg;
        logic                          over;
        logic                          deg;
    } side_t;

endpackage

FILE: design/cps_front.sv
module cps_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] sx,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] sy,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] ex,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] ey,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] px,
    input  logic signed [cps_pkg::COORD_WIDTH-1:0] py,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [cps_pkg::RW-1:0]            num,
    output logic [cps_pkg::PW-1:0]            den,
    output cps_pkg::side_t                    side
);
    localparam int DW = cps_pkg::DW;
    localparam int PW = cps_pkg::PW;
    localparam int NW = cps_pkg::NW;
    localparam int RW = cps_pkg::RW;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    cps_pkg::side_t side1_reg, side2_reg, side3_reg;
    logic signed [DW-1:0] qx1_reg, qy1_reg;
    logic signed [PW-1:0] pqx_reg, pqy_reg, pdx_reg, pdy_reg;
    logic [RW-1:0] num_reg;
    logic [PW-1:0] den_reg;

    logic signed [DW-1:0] dx_next, dy_next;
    logic signed [NW-1:0] num_next;
    logic [PW-1:0] den_next;
    cps_pkg::side_t side3_next;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign dx_next = DW'(ex) - DW'(sx);
    assign dy_next = DW'(ey) - DW'(sy);
    assign num_next = NW'(pqx_reg) + NW'(pqy_reg);
    assign den_next = PW'($unsigned(pdx_reg) + $unsigned(pdy_reg));

    always_comb begin
        side3_next      = side2_reg;
        side3_next.neg  = num_next[NW-1];
        side3_next.over = num_next > $signed({1'b0, den_next});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
        if (rdy1) begin
            side1_reg.sx   <= sx;
            side1_reg.sy   <= sy;
            side1_reg.ex   <= ex;
            side1_reg.ey   <= ey;
            side1_reg.dx   <= dx_next;
            side1_reg.dy   <= dy_next;
            side1_reg.neg  <= 1'b0;
            side1_reg.over <= 1'b0;
            side1_reg.deg  <= (sx == ex) && (sy == ey);
            qx1_reg        <= DW'(px) - DW'(sx);
            qy1_reg        <= DW'(py) - DW'(sy);
        end
        if (rdy2) begin
            side2_reg <= side1_reg;
            pqx_reg   <= qx1_reg * side1_reg.dx;
            pqy_reg   <= qy1_reg * side1_reg.dy;
            pdx_reg   <= side1_reg.dx * side1_reg.dx;
            pdy_reg   <= side1_reg.dy * side1_reg.dy;
        end
        if (rdy3) begin
            side3_reg <= side3_next;
            num_reg   <= RW'($unsigned(num_next));
            den_reg   <= den_next;
        end
    end

    assign out_valid = v3_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side3_reg;
endmodule

FILE: design/cps_div.sv
module cps_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [cps_pkg::RW-1:0] num,
    input  logic [cps_pkg::PW-1:0] den,
    input  cps_pkg::side_t         side_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [cps_pkg::UW-1:0] quo,
    output cps_pkg::side_t         side_out
);
    localparam int N  = cps_pkg::DIV_STAGES;
    localparam int RW = cps_pkg::RW;
    localparam int PW = cps_pkg::PW;
    localparam int UW = cps_pkg::UW;

    logic           v_reg   [N];
    logic [RW-1:0]  r_reg   [N];
    logic [UW-1:0]  u_reg   [N];
    logic [PW-1:0]  d_reg   [N];
    cps_pkg::side_t s_reg   [N];
    logic           rdy     [N+1];

    assign rdy[N]   = out_ready;
    assign in_ready = rdy[0];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [RW-1:0]  r_in;
        logic [UW-1:0]  u_in;
        logic [PW-1:0]  d_in;
        cps_pkg::side_t s_in;
        logic           v_in;
        logic           ge;

        if (i == 0) begin : g_first
            assign r_in = num;
            assign u_in = '0;
            assign d_in = den;
            assign s_in = side_in;
            assign v_in = in_valid;
        end else begin : g_next
            assign r_in = {r_reg[i-1][RW-2:0], 1'b0};
            assign u_in = {u_reg[i-1][UW-2:0], 1'b0};
            assign d_in = d_reg[i-1];
            assign s_in = s_reg[i-1];
            assign v_in = v_reg[i-1];
        end

        assign ge     = r_in >= RW'(d_in);
        assign rdy[i] = !v_reg[i] || rdy[i+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= v_in;
            end
            if (rdy[i]) begin
                r_reg[i] <= ge ? r_in - RW'(d_in) : r_in;
                u_reg[i] <= {u_in[UW-1:1], ge};
                d_reg[i] <= d_in;
                s_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quo       = u_reg[N-1];
    assign side_out  = s_reg[N-1];
endmodule

FILE: design/cps_interp.sv
module cps_interp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [cps_pkg::UW-1:0]                 quo,
    input  cps_pkg::side_t                         side,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [cps_pkg::COORD_WIDTH-1:0] rx,
    output logic signed [cps_pkg::COORD_WIDTH-1:0] ry,
    output logic                                   deg
);
    localparam int CW = cps_pkg::COORD_WIDTH;
    localparam int MW = cps_pkg::MW;

    logic va_reg, vb_reg, rdya, rdyb;
    cps_pkg::side_t sa_reg;
    logic signed [MW-1:0] mx_reg, my_reg;
    logic signed [MW-1:0] shx, shy;
    logic signed [CW-1:0] rx_next, ry_next, rx_reg, ry_reg;
    logic deg_reg;

    assign rdyb     = !vb_reg || out_ready;
    assign rdya     = !va_reg || rdyb;
    assign in_ready = rdya;

    assign shx = mx_reg >>> cps_pkg::FRAC_U;
    assign shy = my_reg >>> cps_pkg::FRAC_U;

    always_comb begin
        if (sa_reg.deg) begin
            rx_next = '0;
            ry_next = '0;
        end else if (sa_reg.neg) begin
            rx_next = sa_reg.sx;
            ry_next = sa_reg.sy;
        end else if (sa_reg.over) begin
            rx_next = sa_reg.ex;
            ry_next = sa_reg.ey;
        end else begin
            rx_next = sa_reg.sx + shx[CW-1:0];
            ry_next = sa_reg.sy + shy[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (rdya) va_reg <= in_valid;
            if (rdyb) vb_reg <= va_reg;
        end
        if (rdya) begin
            sa_reg <= side;
            mx_reg <= $signed({1'b0, quo}) * side.dx;
            my_reg <= $signed({1'b0, quo}) * side.dy;
        end
        if (rdyb) begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            deg_reg <= sa_reg.deg;
        end
    end

    assign out_valid = vb_reg;
    assign rx        = rx_reg;
    assign ry        = ry_reg;
    assign deg       = deg_reg;
endmodule

FILE: design/closest_point_on_segment_unit.sv
// Throughput: one item per cycle unless m_tready stalls; the restoring divider is
// unrolled one quotient bit per stage, so a free stage takes a new item each cycle.
// A stalled output holds its item; empty stages still fill behind it.
// Reset: aresetn synchronous, active low; clears all stage valid bits.
module closest_point_on_segment_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, query_x, query_y
    input  logic [cps_pkg::IN_BYTES_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // nearest_x, nearest_y
    output logic [cps_pkg::OUT_BYTES_W-1:0]     m_tdata,
    // degenerate
    output logic                                m_tuser
);
    localparam int CW = cps_pkg::COORD_WIDTH;

    logic f_valid, f_ready, d_valid, d_ready;
    logic [cps_pkg::RW-1:0] num;
    logic [cps_pkg::PW-1:0] den;
    logic [cps_pkg::UW-1:0] quo;
    cps_pkg::side_t f_side, d_side;
    logic signed [CW-1:0] rx, ry;

    cps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sx        ($signed(s_tdata[0*CW +: CW])),
        .sy        ($signed(s_tdata[1*CW +: CW])),
        .ex        ($signed(s_tdata[2*CW +: CW])),
        .ey        ($signed(s_tdata[3*CW +: CW])),
        .px        ($signed(s_tdata[4*CW +: CW])),
        .py        ($signed(s_tdata[5*CW +: CW])),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .num       (num),
        .den       (den),
        .side      (f_side)
    );

    cps_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .num       (num),
        .den       (den),
        .side_in   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .quo       (quo),
        .side_out  (d_side)
    );

    cps_interp u_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d_valid),
        .in_ready  (d_ready),
        .quo       (quo),
        .side      (d_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rx        (rx),
        .ry        (ry),
        .deg       (m_tuser)
    );

    assign m_tdata = cps_pkg::OUT_BYTES_W'({ry, rx});
endmodule
